// ----- rtl/core/rdsge_pkg.sv -----
// ----------------------------------------------------------------------------
// rdsge_pkg: shared types of the RDS group encoder
// Configuration bundle and the group word that travels from the front part
// through the queue to the block serializer.
// ----------------------------------------------------------------------------
package rdsge_pkg;

  // configuration registers as seen by the front and back parts
  typedef struct packed {
    logic [15:0] pi_code;
    logic        traffic_announcement;
    logic [63:0] station_name;
  } cfg_t;

  // blocks B, C and D of one group; block A is always the PI code
  typedef struct packed {
    logic [15:0] blk_b;
    logic [15:0] blk_c;
    logic [15:0] blk_d;
  } grp_t;

endpackage

// ----- rtl/core/rdsge_front.sv -----
// ----------------------------------------------------------------------------
// rdsge_front: request classifier and radiotext store
// Accepts words, writes radiotext characters, decides the group type of each
// request and builds blocks B to D, one group word per request.
// ----------------------------------------------------------------------------
module rdsge_front #(
  parameter int TEXT_LENGTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  rdsge_pkg::cfg_t     cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [5:0]          text_index,
  input  logic [7:0]          text_char,
  input  logic [16:0]         utc_day_number,
  input  logic [4:0]          utc_hour,
  input  logic [5:0]          utc_min,
  input  logic signed [6:0]   local_offset,
  output logic                grp_valid,
  input  logic                grp_ready,
  output rdsge_pkg::grp_t     grp
);

  localparam int TEXT_SEGS  = TEXT_LENGTH / 4;
  localparam int TEXT_CHARS = TEXT_SEGS * 4;
  localparam int SEG_W      = (TEXT_SEGS > 1) ? $clog2(TEXT_SEGS) : 1;

  localparam logic [15:0] TP_FLAG   = 16'h0400;
  localparam logic [15:0] TA_FLAG   = 16'h0010;
  localparam logic [15:0] AF_NONE   = 16'hCDCD;
  localparam logic [15:0] TYPE_0A   = 16'h0000;
  localparam logic [15:0] TYPE_2A   = 16'h2000;
  localparam logic [15:0] TYPE_4A   = 16'h4000;
  localparam logic [4:0]  MAG_MAX   = 5'h1F;
  localparam logic [7:0]  SPACE_CHR = 8'h20;
  localparam logic [2:0]  PHASE_TXT = 3'd4;

  // sequencing state
  logic [1:0]        name_segment;
  logic [SEG_W-1:0]  text_segment;
  logic [2:0]        cycle_phase;
  logic              stamp_valid;
  logic [27:0]       stamp_minute;

  // radiotext store: one row of four characters per segment
  logic [31:0]           text_mem [TEXT_SEGS];
  logic [TEXT_CHARS-1:0] text_vld;
  logic [31:0]           rd_data;
  logic [3:0]            rd_vld;

  // job stage
  logic              job_valid;
  logic              job_text;
  rdsge_pkg::grp_t   job;

  logic              accept;
  logic              req;
  logic              wr;
  logic [SEG_W-1:0]  wr_row;
  logic [1:0]        wr_lane;
  logic [27:0]       stamp;
  logic              is_clock;
  logic              is_text;
  logic [6:0]        off_raw;
  logic              off_neg;
  logic [6:0]        off_mag;
  logic [4:0]        off_sat;
  rdsge_pkg::grp_t   build;
  logic [7:0]        chr [4];

  assign in_ready = !job_valid || grp_ready;
  assign accept   = in_valid && in_ready;
  assign req      = accept && !action;
  assign wr       = accept && action && ({1'b0, text_index} < 7'(TEXT_CHARS));
  assign wr_row   = text_index[2 +: SEG_W];
  assign wr_lane  = text_index[1:0];

  // group classification
  assign stamp    = {utc_day_number, utc_hour, utc_min};
  assign is_clock = stamp_valid && (stamp != stamp_minute);
  assign is_text  = !is_clock && (cycle_phase == PHASE_TXT);

  // offset magnitude, saturated
  assign off_raw = local_offset;
  assign off_neg = off_raw[6];
  assign off_mag = off_neg ? (7'd0 - off_raw) : off_raw;
  assign off_sat = (off_mag > {2'b00, MAG_MAX}) ? MAG_MAX : off_mag[4:0];

  // blocks B to D of the chosen group type
  always_comb begin
    build = '0;
    if (is_clock) begin
      build.blk_b = TYPE_4A | TP_FLAG | {14'd0, utc_day_number[16:15]};
      build.blk_c = {utc_day_number[14:0], utc_hour[4]};
      build.blk_d = {utc_hour[3:0], utc_min, off_neg, off_sat};
    end else if (is_text) begin
      build.blk_b = TYPE_2A | TP_FLAG | {12'd0, 4'(text_segment)};
    end else begin
      build.blk_b = TYPE_0A | TP_FLAG | {14'd0, name_segment} |
                    (cfg.traffic_announcement ? TA_FLAG : 16'h0000);
      build.blk_c = AF_NONE;
      build.blk_d = cfg.station_name[{~name_segment, 4'b0000} +: 16];
    end
  end

  // sequencing state update
  always_ff @(posedge clk) begin
    if (rst) begin
      name_segment <= '0;
      text_segment <= '0;
      cycle_phase  <= '0;
      stamp_valid  <= 1'b0;
      stamp_minute <= '0;
    end else if (req) begin
      stamp_valid  <= 1'b1;
      stamp_minute <= stamp;
      if (!is_clock) begin
        cycle_phase <= (cycle_phase == PHASE_TXT) ? 3'd0 : cycle_phase + 3'd1;
        if (is_text) begin
          text_segment <= (text_segment == SEG_W'(TEXT_SEGS - 1)) ? '0
                          : text_segment + SEG_W'(1);
        end else begin
          name_segment <= name_segment + 2'd1;
        end
      end
    end
  end

  // text store write and row read
  always_ff @(posedge clk) begin
    if (wr) begin
      text_mem[wr_row][{~wr_lane, 3'b000} +: 8] <= text_char;
    end
    if (req) begin
      rd_data <= text_mem[text_segment];
    end
  end

  // character valid bits: unwritten characters read as spaces
  always_ff @(posedge clk) begin
    if (rst) begin
      text_vld <= '0;
      rd_vld   <= '0;
    end else begin
      if (wr) begin
        text_vld[{wr_row, wr_lane}] <= 1'b1;
      end
      if (req) begin
        rd_vld <= text_vld[{text_segment, 2'b00} +: 4];
      end
    end
  end

  // job stage
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (req) begin
      job_valid <= 1'b1;
    end else if (grp_ready) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      job      <= build;
      job_text <= is_text;
    end
  end

  // merge text row into the group word; character i sits in the top byte first
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      chr[i] = rd_vld[i] ? rd_data[(3 - i) * 8 +: 8] : SPACE_CHR;
    end
    grp = job;
    if (job_text) begin
      grp.blk_c = {chr[0], chr[1]};
      grp.blk_d = {chr[2], chr[3]};
    end
  end

  assign grp_valid = job_valid;

endmodule

// ----- rtl/core/rdsge_queue.sv -----
// ----------------------------------------------------------------------------
// rdsge_queue: two-entry group queue
// Decouples the classifier from the block serializer so either side can stall.
// ----------------------------------------------------------------------------
module rdsge_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rdsge_pkg::grp_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rdsge_pkg::grp_t  out_data
);

  rdsge_pkg::grp_t slot [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slot[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

// ----- rtl/core/rdsge_back.sv -----
// ----------------------------------------------------------------------------
// rdsge_back: block serializer
// Sends blocks A to D of the head group, one per cycle unless stalled, each
// with its CRC xored with the block offset word, through an output register.
// ----------------------------------------------------------------------------
module rdsge_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      pi_code,
  input  logic             grp_valid,
  output logic             grp_ready,
  input  rdsge_pkg::grp_t  grp,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      info_word,
  output logic [9:0]       check_word,
  output logic             block_last
);

  localparam logic [1:0] BLK_A = 2'd0;
  localparam logic [1:0] BLK_B = 2'd1;
  localparam logic [1:0] BLK_C = 2'd2;
  localparam logic [1:0] BLK_D = 2'd3;

  // remainder of x^(k+10) for each message bit k
  localparam logic [15:0][9:0] CRC_BIT = {
    10'h077, 10'h2E7, 10'h3AF, 10'h30B, 10'h359, 10'h370, 10'h1B8, 10'h0DC,
    10'h06E, 10'h037, 10'h2C7, 10'h3BF, 10'h303, 10'h35D, 10'h372, 10'h1B9
  };

  localparam logic [3:0][9:0] OFFSET_WORD = {10'h1B4, 10'h168, 10'h198, 10'h0FC};

  logic [1:0]  blk_idx;
  logic        load;
  logic [15:0] word;
  logic [9:0]  crc;

  assign load      = !out_valid || out_ready;
  assign grp_ready = load && (blk_idx == BLK_D);

  // block word select
  always_comb begin
    unique case (blk_idx)
      BLK_A:   word = pi_code;
      BLK_B:   word = grp.blk_b;
      BLK_C:   word = grp.blk_c;
      BLK_D:   word = grp.blk_d;
      default: word = pi_code;
    endcase
  end

  // CRC is linear: xor the remainders of the set bits
  always_comb begin
    crc = 10'd0;
    for (int k = 0; k < 16; k++) begin
      if (word[k]) begin
        crc = crc ^ CRC_BIT[k];
      end
    end
  end

  // block counter and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_idx   <= BLK_A;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= grp_valid;
      if (grp_valid) begin
        blk_idx <= blk_idx + 2'd1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (load && grp_valid) begin
      info_word  <= word;
      check_word <= crc ^ OFFSET_WORD[blk_idx];
      block_last <= (blk_idx == BLK_D);
    end
  end

endmodule

// ----- rtl/core/rds_group_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// rds_group_encoder_unit: RDS group builder
// Input words either write one radiotext character (action 1) or request the
// next group (action 0), carrying the UTC date, hour, minute and offset.
// Each request yields four output words, blocks A to D, with block_last set
// on block D. A new minute yields a clock-time group; otherwise groups cycle
// through four station-name groups and one radiotext group.
// Configuration: cfg_index 0 PI code, 1 TA flag, 2 station name; other
// indexes are ignored. cfg_ready is always high.
// Timing: the first block of a request passes through the request stage,
// the queue and the output register; the blocks then follow one per cycle
// while out_ready is high. A character write gives no output. Throughput
// is set by the block serializer; a two-group queue lets requests and
// writes be accepted while earlier groups are still being sent.
// Reset: sequencing state cleared, station name set to spaces, every
// radiotext character reads as a space until written.
// Stall: when out_ready is low the output word holds; once the queue and the
// request stage fill, in_ready drops.
// ----------------------------------------------------------------------------
module rds_group_encoder_unit #(
  parameter int TEXT_LENGTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [5:0]         text_index,
  input  logic [7:0]         text_char,
  input  logic [16:0]        utc_day_number,
  input  logic [4:0]         utc_hour,
  input  logic [5:0]         utc_min,
  input  logic signed [6:0]  local_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        info_word,
  output logic [9:0]         check_word,
  output logic               block_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam logic [1:0]  REG_PI   = 2'd0;
  localparam logic [1:0]  REG_TA   = 2'd1;
  localparam logic [1:0]  REG_NAME = 2'd2;
  localparam logic [63:0] NAME_RST = 64'h2020202020202020;

  rdsge_pkg::cfg_t cfg;
  rdsge_pkg::grp_t front_grp;
  rdsge_pkg::grp_t q_grp;
  logic            front_valid;
  logic            front_ready;
  logic            q_out_valid;
  logic            q_out_ready;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pi_code              <= 16'h0000;
      cfg.traffic_announcement <= 1'b0;
      cfg.station_name         <= NAME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PI:   cfg.pi_code              <= cfg_data[15:0];
        REG_TA:   cfg.traffic_announcement <= cfg_data[0];
        REG_NAME: cfg.station_name         <= cfg_data;
        default:  ;
      endcase
    end
  end

  rdsge_front #(
    .TEXT_LENGTH(TEXT_LENGTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .text_index     (text_index),
    .text_char      (text_char),
    .utc_day_number (utc_day_number),
    .utc_hour       (utc_hour),
    .utc_min        (utc_min),
    .local_offset   (local_offset),
    .grp_valid      (front_valid),
    .grp_ready      (front_ready),
    .grp            (front_grp)
  );

  rdsge_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_grp),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_data  (q_grp)
  );

  rdsge_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pi_code    (cfg.pi_code),
    .grp_valid  (q_out_valid),
    .grp_ready  (q_out_ready),
    .grp        (q_grp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .info_word  (info_word),
    .check_word (check_word),
    .block_last (block_last)
  );

  // the word after block D is block A of the next group
  a_block_a_after_last: assert property (@(posedge clk) disable iff (rst)
    ($past(out_valid && out_ready && block_last) && out_valid)
      |-> (info_word == cfg.pi_code && !block_last))
    else $error("group did not start with the PI block");

  // with nothing queued, the output empties after block D
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && block_last && !q_out_valid) |=> !out_valid)
    else $error("output word invented after last block");

  // input stalls only when the request stage is held by a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (front_valid && !front_ready))
    else $error("input stalled without back pressure");

endmodule

// ----- sim/rdsge_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsge_tb_pkg: codes shared by the RDS encoder testbench
// Input word actions and configuration register indexes, used by both the
// stimulus side and the checker.
// ----------------------------------------------------------------------------
package rdsge_tb_pkg;

  // action field of an input word
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_WRITE   = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_PI_CODE      = 2'd0;
  localparam logic [1:0] REG_TA           = 2'd1;
  localparam logic [1:0] REG_STATION_NAME = 2'd2;
  localparam logic [1:0] REG_UNUSED       = 2'd3;

endpackage

// ----- sim/rds_group_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rds_group_checker: scoreboard for the RDS group encoder
// Watches the input, output and configuration channels, builds the four
// expected blocks of every accepted group request with its own copy of the
// sequencing state, and compares each output word against the oldest one.
// ----------------------------------------------------------------------------
module rds_group_checker #(
  parameter int TEXT_LENGTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        action,
  input  logic [5:0]  text_index,
  input  logic [7:0]  text_char,
  input  logic [16:0] utc_day_number,
  input  logic [4:0]  utc_hour,
  input  logic [5:0]  utc_min,
  input  logic [6:0]  local_offset,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] info_word,
  input  logic [9:0]  check_word,
  input  logic        block_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          blocks_checked,
  output int          time_groups
);

  localparam int TEXT_SEGS = TEXT_LENGTH / 4;

  localparam logic [9:0]  CRC_GEN   = 10'h1B9;
  localparam logic [15:0] GRP_0A    = 16'h0000;
  localparam logic [15:0] GRP_2A    = 16'h2000;
  localparam logic [15:0] GRP_4A    = 16'h4000;
  localparam logic [15:0] TP_BIT    = 16'h0400;
  localparam logic [15:0] TA_BIT    = 16'h0010;
  localparam logic [15:0] NO_AF     = 16'hCDCD;
  localparam logic [4:0]  MAG_LIMIT = 5'h1F;
  // offset words of blocks A..D, block A in the low bits
  localparam logic [39:0] BLOCK_OFFSETS = {10'h1B4, 10'h168, 10'h198, 10'h0FC};

  typedef struct packed {
    logic [15:0] info;
    logic [9:0]  check;
    logic        last;
  } block_word_t;

  block_word_t expected_blocks[$];

  // model copy of configuration and sequencing state
  rdsge_pkg::cfg_t cfg;
  logic [1:0]      name_seg;
  int unsigned     text_seg;
  int unsigned     group_phase;
  logic            stamp_valid;
  logic [27:0]     minute_stamp;
  logic [7:0]      text_store [64];

  // 10-bit block check word, MSB first
  function automatic logic [9:0] rds_crc10(input logic [15:0] word);
    logic [9:0] crc;
    logic       fb;
    int         k;
    crc = '0;
    for (k = 15; k >= 0; k--) begin
      fb  = word[k] ^ crc[9];
      crc = {crc[8:0], 1'b0};
      if (fb) crc = crc ^ CRC_GEN;
    end
    return crc;
  endfunction

  // build the four blocks of the next group and queue them
  task automatic build_group(input logic [16:0] day, input logic [4:0] hour,
                             input logic [5:0] minute, input logic [6:0] offset);
    logic [3:0][15:0] blk;
    logic [27:0]      stamp;
    logic [6:0]       mag7;
    logic [4:0]       mag;
    logic             neg;
    logic             time_group;
    int unsigned      s;
    int unsigned      b;
    block_word_t      w;
    int               i;
    stamp      = {day, hour, minute};
    blk[0]     = cfg.pi_code;
    time_group = 1'b0;
    if (!stamp_valid) begin
      stamp_valid  = 1'b1;
      minute_stamp = stamp;
    end else if (minute_stamp != stamp) begin
      // clock-time group, sign and saturated magnitude of the offset
      neg = offset[6];
      if (neg) mag7 = 7'd0 - offset;
      else mag7 = offset;
      mag = (mag7 > 7'(MAG_LIMIT)) ? MAG_LIMIT : mag7[4:0];
      minute_stamp = stamp;
      time_group   = 1'b1;
      blk[1] = GRP_4A | TP_BIT | {14'd0, day[16:15]};
      blk[2] = {day[14:0], hour[4]};
      blk[3] = {hour[3:0], minute, neg, mag};
      time_groups++;
    end
    if (!time_group) begin
      if (group_phase < 4) begin
        // station-name segment
        s = {30'd0, name_seg};
        blk[1] = GRP_0A | TP_BIT | {14'd0, name_seg} |
                 (cfg.traffic_announcement ? TA_BIT : 16'h0000);
        blk[2] = NO_AF;
        blk[3] = cfg.station_name[63 - 16 * s -: 16];
        name_seg = name_seg + 2'd1;
      end else begin
        // radiotext segment
        s = text_seg % TEXT_SEGS;
        b = (s * 4) & 63;
        blk[1] = GRP_2A | TP_BIT | {12'd0, 4'(s)};
        blk[2] = {text_store[b], text_store[b + 1]};
        blk[3] = {text_store[b + 2], text_store[b + 3]};
        text_seg = (s + 1) % TEXT_SEGS;
      end
      group_phase = (group_phase + 1) % 5;
    end
    for (i = 0; i < 4; i++) begin
      w.info  = blk[i];
      w.check = rds_crc10(blk[i]) ^ BLOCK_OFFSETS[10 * i +: 10];
      w.last  = (i == 3);
      expected_blocks.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    block_word_t exp_w;
    if (rst) begin
      cfg.pi_code              = '0;
      cfg.traffic_announcement = 1'b0;
      cfg.station_name         = 64'h2020_2020_2020_2020;
      name_seg     = '0;
      text_seg     = 0;
      group_phase  = 0;
      stamp_valid  = 1'b0;
      minute_stamp = '0;
      for (int i = 0; i < 64; i++) text_store[i] = 8'h20;
      expected_blocks.delete();
      fail_count     = 0;
      blocks_checked = 0;
      time_groups    = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rdsge_tb_pkg::REG_PI_CODE:      cfg.pi_code = cfg_data[15:0];
          rdsge_tb_pkg::REG_TA:           cfg.traffic_announcement = cfg_data[0];
          rdsge_tb_pkg::REG_STATION_NAME: cfg.station_name = cfg_data;
          default: ;
        endcase
      end
      // input words
      if (in_valid && in_ready) begin
        if (action == rdsge_tb_pkg::ACT_WRITE) begin
          if (int'(text_index) < TEXT_LENGTH) text_store[text_index] = text_char;
        end else begin
          build_group(utc_day_number, utc_hour, utc_min, local_offset);
        end
      end
      // output words
      if (out_valid && out_ready) begin
        blocks_checked++;
        if (expected_blocks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected block info %h check %h last %b",
                     $realtime, info_word, check_word, block_last);
        end else begin
          exp_w = expected_blocks.pop_front();
          if (info_word !== exp_w.info || check_word !== exp_w.check ||
              block_last !== exp_w.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: block mismatch: expected info %h check %h last %b, got %h %h %b",
                       $realtime, exp_w.info, exp_w.check, exp_w.last,
                       info_word, check_word, block_last);
          end
        end
      end
    end
    pending = expected_blocks.size();
  end

endmodule

// ----- sim/tb_rds_group_encoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rds_group_encoder_unit: testbench for the RDS group encoder
// Drives directed and random group requests and radiotext writes under four
// register settings and three idling patterns; a checker beside the block
// predicts every output word and reports the failures.
// ----------------------------------------------------------------------------
module tb_rds_group_encoder_unit;

  localparam int TEXT_LENGTH = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_WORDS = 130;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               action;
  logic [5:0]         text_index;
  logic [7:0]         text_char;
  logic [16:0]        utc_day_number;
  logic [4:0]         utc_hour;
  logic [5:0]         utc_min;
  logic signed [6:0]  local_offset;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        info_word;
  logic [9:0]         check_word;
  logic               block_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [63:0]        cfg_data;

  int fail_count;
  int pending;
  int blocks_checked;
  int time_groups;

  int send_idle_pct;
  int recv_idle_pct;
  int requests_sent;
  int writes_sent;
  int reg_writes;
  int stalled;

  // current UTC time carried by requests
  logic [16:0] cur_day;
  logic [4:0]  cur_hour;
  logic [5:0]  cur_min;

  rds_group_encoder_unit #(.TEXT_LENGTH(TEXT_LENGTH)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .text_index     (text_index),
    .text_char      (text_char),
    .utc_day_number (utc_day_number),
    .utc_hour       (utc_hour),
    .utc_min        (utc_min),
    .local_offset   (local_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .info_word      (info_word),
    .check_word     (check_word),
    .block_last     (block_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  rds_group_checker #(.TEXT_LENGTH(TEXT_LENGTH)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .text_index     (text_index),
    .text_char      (text_char),
    .utc_day_number (utc_day_number),
    .utc_hour       (utc_hour),
    .utc_min        (utc_min),
    .local_offset   (local_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .info_word      (info_word),
    .check_word     (check_word),
    .block_last     (block_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .blocks_checked (blocks_checked),
    .time_groups    (time_groups)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: too long without any word moving on any channel
  initial begin
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("Some tests failed");
    $finish;
  end

  // present one input word, called and returning at a falling edge
  task automatic send_word(input logic act, input logic [5:0] idx, input logic [7:0] ch,
                           input logic [16:0] day, input logic [4:0] hour,
                           input logic [5:0] minute, input logic [6:0] offset);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    text_index     <= idx;
    text_char      <= ch;
    utc_day_number <= day;
    utc_hour       <= hour;
    utc_min        <= minute;
    local_offset   <= offset;
    do @(posedge clk); while (!in_ready);
    if (act == rdsge_tb_pkg::ACT_WRITE) writes_sent++;
    else requests_sent++;
    @(negedge clk);
  endtask

  // request with the current time
  task automatic request_now(input logic [6:0] offset);
    send_word(rdsge_tb_pkg::ACT_REQUEST, 6'($urandom_range(63)), 8'($urandom_range(255)),
              cur_day, cur_hour, cur_min, offset);
  endtask

  // write all registers, plus the unused index
  task automatic load_settings(input logic [15:0] pi, input logic ta,
                               input logic [63:0] name);
    logic [1:0]  idx [4];
    logic [63:0] val [4];
    int          i;
    idx[0] = rdsge_tb_pkg::REG_PI_CODE;      val[0] = {48'($urandom()), pi};
    idx[1] = rdsge_tb_pkg::REG_TA;           val[1] = {63'($urandom()), ta};
    idx[2] = rdsge_tb_pkg::REG_STATION_NAME; val[2] = name;
    idx[3] = rdsge_tb_pkg::REG_UNUSED;       val[3] = {$urandom(), $urandom()};
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      reg_writes++;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // stop sending and wait until every expected block is out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // random offset, mostly within the legal range
  function automatic logic [6:0] pick_offset();
    int o;
    if ($urandom_range(99) < 80) begin
      o = $urandom_range(96) - 48;
      return o[6:0];
    end
    return 7'($urandom_range(127));
  endfunction

  // random traffic: mostly same-minute requests, some minute changes and writes
  task automatic run_random(input int count);
    int n;
    int r;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 20) begin
        send_word(rdsge_tb_pkg::ACT_WRITE, 6'($urandom_range(63)),
                  8'($urandom_range(255)),
                  17'($urandom_range(131071)), 5'($urandom_range(31)),
                  6'($urandom_range(63)), pick_offset());
      end else begin
        if (r < 30) begin
          if ($urandom_range(99) < 30) begin
            cur_day  = 17'($urandom_range(131071));
            cur_hour = 5'($urandom_range(31));
            cur_min  = 6'($urandom_range(63));
          end else if (cur_min >= 6'd59) begin
            cur_min = 6'd0;
            if (cur_hour >= 5'd23) begin
              cur_hour = 5'd0;
              cur_day  = cur_day + 17'd1;
            end else begin
              cur_hour = cur_hour + 5'd1;
            end
          end else begin
            cur_min = cur_min + 6'd1;
          end
        end
        request_now(pick_offset());
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = rdsge_tb_pkg::ACT_REQUEST;
    text_index     = '0;
    text_char      = '0;
    utc_day_number = '0;
    utc_hour       = '0;
    utc_min        = '0;
    local_offset   = '0;
    cfg_valid      = 1'b0;
    cfg_index      = rdsge_tb_pkg::REG_PI_CODE;
    cfg_data       = '0;
    send_idle_pct  = 7;
    recv_idle_pct  = 81;
    requests_sent  = 0;
    writes_sent    = 0;
    reg_writes     = 0;
    cur_day        = 17'd60000;
    cur_hour       = 5'd12;
    cur_min        = 6'd30;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // directed part
    load_settings(16'hC201, 1'b1, 64'h5445_5354_464D_2020);
    request_now(7'd0);                    // first request records the time, no clock-time group
    request_now(7'd0);
    request_now(7'd0);
    send_word(rdsge_tb_pkg::ACT_WRITE, 6'd0, 8'h00, 17'd0, 5'd0, 6'd0, 7'd0);
    send_word(rdsge_tb_pkg::ACT_WRITE, 6'd1, 8'hFF, 17'h1FFFF, 5'd31, 6'd63, 7'h7F);
    send_word(rdsge_tb_pkg::ACT_WRITE, 6'd2, 8'h52, cur_day, cur_hour, cur_min, 7'd0);
    send_word(rdsge_tb_pkg::ACT_WRITE, 6'd3, 8'h44, cur_day, cur_hour, cur_min, 7'd0);
    send_word(rdsge_tb_pkg::ACT_WRITE, 6'd63, 8'hA5, cur_day, cur_hour, cur_min, 7'd0);
    request_now(7'd0);                    // last name segment
    request_now(7'd0);                    // radiotext segment 0
    send_word(rdsge_tb_pkg::ACT_REQUEST, 6'd0, 8'd0, 17'd60000, 5'd12, 6'd31, 7'd48);
    // -48
    send_word(rdsge_tb_pkg::ACT_REQUEST, 6'd0, 8'd0, 17'h1FFFF, 5'd31, 6'd63, 7'h50);
    // -64 saturates
    send_word(rdsge_tb_pkg::ACT_REQUEST, 6'd0, 8'd0, 17'd0, 5'd0, 6'd0, 7'h40);
    // +63 saturates
    send_word(rdsge_tb_pkg::ACT_REQUEST, 6'd0, 8'd0, 17'd0, 5'd23, 6'd59, 7'h3F);
    // same minute
    send_word(rdsge_tb_pkg::ACT_REQUEST, 6'd0, 8'd0, 17'd0, 5'd23, 6'd59, 7'h7F);
    send_word(rdsge_tb_pkg::ACT_REQUEST, 6'd0, 8'd0, 17'd1, 5'd16, 6'd1, 7'd32);
    send_word(rdsge_tb_pkg::ACT_REQUEST, 6'd0, 8'd0, 17'd1, 5'd16, 6'd1, 7'd31);
    cur_day  = 17'd1;
    cur_hour = 5'd16;
    cur_min  = 6'd1;

    // random, slow receiver, with one full drain halfway
    drain();
    repeat (8) @(negedge clk);
    load_settings(16'h0000, 1'b0, 64'h0);
    run_random(PHASE_WORDS / 2);
    drain();
    run_random(PHASE_WORDS - PHASE_WORDS / 2);

    // random, slow sender
    drain();
    repeat (8) @(negedge clk);
    send_idle_pct = 81;
    recv_idle_pct = 7;
    load_settings(16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    run_random(PHASE_WORDS);

    // random, no idling
    drain();
    repeat (8) @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings(16'($urandom()), 1'($urandom()), {$urandom(), $urandom()});
    run_random(PHASE_WORDS);

    // let everything drain and watch for stray words
    drain();
    repeat (20) @(negedge clk);

    $display("Covered %0d group requests, %0d radiotext writes, %0d register writes",
             requests_sent, writes_sent, reg_writes);
    $display("Checked %0d blocks, %0d clock-time groups", blocks_checked, time_groups);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rdsge_pkg.sv
rtl/core/rdsge_front.sv
rtl/core/rdsge_queue.sv
rtl/core/rdsge_back.sv
rtl/core/rds_group_encoder_unit.sv
sim/rdsge_tb_pkg.sv
sim/rds_group_checker.sv
sim/tb_rds_group_encoder_unit.sv
